// File: src/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared definitions for the contrast stretch core
// Command codes and the depth of the queue between the front and back parts.
// ----------------------------------------------------------------------------
package csm_pkg;

    typedef enum logic {
        CMD_SCAN = 1'b0,
        CMD_MAP  = 1'b1
    } cmd_t;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

endpackage

// File: src/csm_queue.sv
// ----------------------------------------------------------------------------
// csm_queue: short queue between front and back
// Register-based queue that holds pending map requests with their min/max.
// ----------------------------------------------------------------------------
module csm_queue #(
    parameter int WIDTH = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr,
    input  logic [WIDTH-1:0]                  wr_data,
    input  logic                              rd,
    output logic [WIDTH-1:0]                  rd_data,
    output logic                              q_full,
    output logic                              q_empty,
    output logic [csm_pkg::QUEUE_CNT_BITS-1:0] q_count
);
    import csm_pkg::*;

    logic [WIDTH-1:0]          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] head_reg;
    logic [QUEUE_PTR_BITS-1:0] head_next;
    logic [QUEUE_PTR_BITS-1:0] tail_reg;
    logic [QUEUE_PTR_BITS-1:0] tail_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      do_wr;
    logic                      do_rd;

    assign q_full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_count = count_reg;
    assign rd_data = entry_reg[head_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (do_rd)
        begin
            head_next = head_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[tail_reg] <= wr_data;
        end
    end

endmodule

// File: src/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front: request intake and min/max tracking
// Scan requests update the frame minimum and maximum; map requests are
// queued together with the current minimum and maximum.
// ----------------------------------------------------------------------------
module csm_front #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      cmd,
    input  logic [PIXEL_BITS-1:0]     pixel,
    input  logic                      in_last,
    output logic                      q_wr,
    output logic [3*PIXEL_BITS:0]     q_wr_data
);
    import csm_pkg::*;

    logic [PIXEL_BITS-1:0] min_reg;
    logic [PIXEL_BITS-1:0] min_next;
    logic [PIXEL_BITS-1:0] max_reg;
    logic [PIXEL_BITS-1:0] max_next;
    logic                  frame_start_reg;
    logic                  frame_start_next;
    logic                  is_scan;

    assign is_scan   = (cmd_t'(cmd) == CMD_SCAN);
    assign q_wr      = accept && !is_scan;
    assign q_wr_data = {in_last, pixel, min_reg, max_reg};

    always_comb
    begin
        min_next         = min_reg;
        max_next         = max_reg;
        frame_start_next = frame_start_reg;
        if (accept && is_scan)
        begin
            if (frame_start_reg)
            begin
                min_next = pixel;
                max_next = pixel;
            end
            else
            begin
                if (pixel < min_reg)
                begin
                    min_next = pixel;
                end
                if (pixel > max_reg)
                begin
                    max_next = pixel;
                end
            end
            frame_start_next = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg         <= '1;
            max_reg         <= '0;
            frame_start_reg <= 1'b1;
        end
        else
        begin
            min_reg         <= min_next;
            max_reg         <= max_next;
            frame_start_reg <= frame_start_next;
        end
    end

endmodule

// File: src/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back: stretch computation and result register
// Takes queued map requests, resolves the special cases, and runs a
// restoring divider one quotient bit per cycle for the rounded stretch.
// ----------------------------------------------------------------------------
module csm_back #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  logic [3*PIXEL_BITS:0]     q_rd_data,
    output logic                      q_rd,
    input  logic                      pop,
    output logic                      empty,
    output logic [PIXEL_BITS-1:0]     out_pixel,
    output logic                      out_last,
    output logic                      flat_image
);
    import csm_pkg::*;

    localparam int PB      = PIXEL_BITS;
    localparam int CW      = $clog2(PB + 1);
    localparam int NW      = 2 * PB + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [PB:0]     rem_reg;
    logic [PB:0]     rem_next;
    logic [PB-1:0]   quo_reg;
    logic [PB-1:0]   quo_next;
    logic [PB:0]     den_reg;
    logic [PB:0]     den_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [PB-1:0]   res_pixel_reg;
    logic [PB-1:0]   res_pixel_next;
    logic            res_last_reg;
    logic            res_last_next;
    logic            res_flat_reg;
    logic            res_flat_next;
    logic [PB-1:0]   out_pixel_reg;
    logic [PB-1:0]   out_pixel_next;
    logic            out_last_reg;
    logic            out_last_next;
    logic            out_flat_reg;
    logic            out_flat_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    logic            e_last;
    logic [PB-1:0]   e_pixel;
    logic [PB-1:0]   e_min;
    logic [PB-1:0]   e_max;
    logic [PB-1:0]   span;
    logic [PB-1:0]   offset;
    logic [2*PB-1:0] scaled;
    logic [NW-1:0]   numer;
    logic [PB+1:0]   trial;
    logic [PB+1:0]   diff;
    logic [PB:0]     quo_shift;
    logic            qbit;

    assign {e_last, e_pixel, e_min, e_max} = q_rd_data;
    assign span   = e_max - e_min;
    assign offset = e_pixel - e_min;
    // offset * (2^PB - 1) without a multiplier.
    assign scaled = {offset, {PB{1'b0}}} - {{PB{1'b0}}, offset};
    assign numer  = {scaled, 1'b0} + {{(PB + 1){1'b0}}, span};

    assign trial     = {rem_reg, quo_reg[PB-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign qbit      = !diff[PB+1];
    assign quo_shift = {quo_reg, qbit};

    assign empty      = !out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign out_last   = out_last_reg;
    assign flat_image = out_flat_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        res_pixel_next = res_pixel_reg;
        res_last_next  = res_last_reg;
        res_flat_next  = res_flat_reg;
        out_pixel_next = out_pixel_reg;
        out_last_next  = out_last_reg;
        out_flat_next  = out_flat_reg;
        out_valid_next = out_valid_reg;
        q_rd           = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd          = 1'b1;
                    res_last_next = e_last;
                    res_flat_next = 1'b0;
                    priority if (e_max <= e_min)
                    begin
                        res_flat_next  = 1'b1;
                        res_pixel_next = '0;
                        state_next     = ST_HOLD;
                    end
                    else if (e_pixel <= e_min)
                    begin
                        res_pixel_next = '0;
                        state_next     = ST_HOLD;
                    end
                    else if (e_pixel >= e_max)
                    begin
                        res_pixel_next = '1;
                        state_next     = ST_HOLD;
                    end
                    else
                    begin
                        // The quotient is known to fit in PB bits, so the upper
                        // numerator bits already sit below the divisor.
                        rem_next   = numer[NW-1:PB];
                        quo_next   = numer[PB-1:0];
                        den_next   = {span, 1'b0};
                        cnt_next   = CW'(PB - 1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (qbit)
                begin
                    rem_next = diff[PB:0];
                end
                else
                begin
                    rem_next = trial[PB:0];
                end
                quo_next = quo_shift[PB-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    res_pixel_next = quo_shift[PB-1:0];
                    state_next     = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_pixel_next = res_pixel_reg;
                    out_last_next  = res_last_reg;
                    out_flat_next  = res_flat_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            den_reg       <= '0;
            res_pixel_reg <= '0;
            res_last_reg  <= 1'b0;
            res_flat_reg  <= 1'b0;
            out_pixel_reg <= '0;
            out_last_reg  <= 1'b0;
            out_flat_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            den_reg       <= den_next;
            res_pixel_reg <= res_pixel_next;
            res_last_reg  <= res_last_next;
            res_flat_reg  <= res_flat_next;
            out_pixel_reg <= out_pixel_next;
            out_last_reg  <= out_last_next;
            out_flat_reg  <= out_flat_next;
        end
    end

endmodule

// File: src/contrast_stretch_minmax_core.sv
// Timing: a scan request takes effect in the next cycle and gives no result. A map
// request passes the queue, ST_IDLE, ST_DIV (skipped in the special cases), ST_HOLD
// and the output register. Scan requests run one per cycle while the queue is not
// full; map requests are finished one at a time; a 4-entry queue absorbs bursts.
// Reset: asynchronous; min 2^PIXEL_BITS - 1, max 0, new frame, queue and result empty.
// ----------------------------------------------------------------------------
// contrast_stretch_minmax_core: min/max linear contrast stretch
// Two-pass grey-level stretch: scan requests find the frame range, map
// requests return the rounded, clipped stretched pixel or a flat flag.
// ----------------------------------------------------------------------------
module contrast_stretch_minmax_core #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  cmd,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic                  in_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIXEL_BITS-1:0] out_pixel,
    output logic                  out_last,
    output logic                  flat_image
);
    import csm_pkg::*;

    localparam int EW = 3 * PIXEL_BITS + 1;

    logic                      accept;
    logic                      q_wr;
    logic [EW-1:0]             q_wr_data;
    logic                      q_rd;
    logic [EW-1:0]             q_rd_data;
    logic                      q_full;
    logic                      q_empty;
    logic [QUEUE_CNT_BITS-1:0] q_count;

    assign full   = q_full;
    assign accept = push && !q_full;

    csm_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .pixel     (pixel),
        .in_last   (in_last),
        .q_wr      (q_wr),
        .q_wr_data (q_wr_data)
    );

    csm_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty),
        .q_count (q_count)
    );

    csm_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_rd_data  (q_rd_data),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .out_pixel  (out_pixel),
        .out_last   (out_last),
        .flat_image (flat_image)
    );

`ifndef ASSERT_OFF
    // A flat image always reports a zero pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && flat_image) |-> (out_pixel == '0))
    else $error("flat image result with nonzero pixel");

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

    // A map request accepted into an empty queue is counted on the next cycle
    // unless the back part took one in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr && !q_rd && q_empty) |=> !q_empty)
    else $error("queued map request lost");
`endif

endmodule
